[sv/pcw_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the polygon convexity and winding checker.
package pcw_pkg;

	localparam int COORD_W   = 24;
	localparam int EPS_W     = 20;
	localparam int MINP_W    = 7;
	localparam int VIEW_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;
	localparam int ACC_W     = 61;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [VIEW_W-1:0] VIEW_XY = 2'd0;
	localparam logic [VIEW_W-1:0] VIEW_YZ = 2'd1;
	localparam logic [VIEW_W-1:0] VIEW_XZ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_PLANE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CROSS_EPSILON = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS    = 2'd2;

	localparam logic [VIEW_W-1:0] VIEW_RESET = VIEW_XY;
	localparam logic [EPS_W-1:0]  EPS_RESET  = 20'd66;
	localparam logic [MINP_W-1:0] MINP_RESET = 7'd3;

	// Position of a vertex within its polygon
	typedef enum logic [1:0] {
		CLS_FIRST  = 2'd0,
		CLS_SECOND = 2'd1,
		CLS_MORE   = 2'd2
	} pcw_cls_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] a;
		logic signed [COORD_W-1:0] b;
	} pcw_pt_t;

	typedef struct packed {
		pcw_pt_t  pt;
		pcw_cls_t cls;
		logic     last;
		logic     too_few;
	} pcw_vtx_t;

	typedef struct packed {
		logic [VIEW_W-1:0] view_plane;
		logic [EPS_W-1:0]  cross_epsilon;
		logic [MINP_W-1:0] min_points;
	} pcw_cfg_t;

endpackage

[sv/pcw_front.sv]
`timescale 1ns / 1ps
// Front end: accepts vertex beats, picks the drawing plane and classifies each vertex.
module pcw_front #(
	parameter int MAX_VERTICES = 1023
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pcw_pkg::pcw_cfg_t              cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [pcw_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pcw_pkg::COORD_W-1:0] coord_y,
	input  logic signed [pcw_pkg::COORD_W-1:0] coord_z,
	input  logic                           last_vertex,
	output logic                           push_valid,
	input  logic                           push_ready,
	output pcw_pkg::pcw_vtx_t              push_data
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W = (CNT_W > pcw_pkg::MINP_W) ? CNT_W : pcw_pkg::MINP_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_inc;
	logic             accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	// saturating count including this vertex
	assign count_inc = (count_q < CNT_MAX) ? count_q + CNT_W'(1) : count_q;

	always_comb begin
		push_data = '0;
		unique case (cfg.view_plane)
			pcw_pkg::VIEW_YZ: begin
				push_data.pt.a = coord_y;
				push_data.pt.b = coord_z;
			end
			pcw_pkg::VIEW_XZ: begin
				push_data.pt.a = coord_x;
				push_data.pt.b = coord_z;
			end
			default: begin
				push_data.pt.a = coord_x;
				push_data.pt.b = coord_y;
			end
		endcase
		if (count_q == '0) begin
			push_data.cls = pcw_pkg::CLS_FIRST;
		end else if (count_q == CNT_W'(1)) begin
			push_data.cls = pcw_pkg::CLS_SECOND;
		end else begin
			push_data.cls = pcw_pkg::CLS_MORE;
		end
		push_data.last    = last_vertex;
		push_data.too_few = CMP_W'(count_inc) < CMP_W'(cfg.min_points);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= last_vertex ? '0 : count_inc;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("vertex count above saturation limit");

endmodule

[sv/pcw_queue.sv]
`timescale 1ns / 1ps
// Short vertex queue between the front end and the arithmetic back end.
module pcw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  pcw_pkg::pcw_vtx_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output pcw_pkg::pcw_vtx_t pop_data
);

	pcw_pkg::pcw_vtx_t                  mem_q [pcw_pkg::QDEPTH];
	logic [pcw_pkg::QPTR_W-1:0]         wr_q;
	logic [pcw_pkg::QPTR_W-1:0]         rd_q;
	logic [pcw_pkg::QCNT_W-1:0]         cnt_q;
	logic                               push;
	logic                               pop;

	assign push_ready = cnt_q != pcw_pkg::QCNT_W'(pcw_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + pcw_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + pcw_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + pcw_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - pcw_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pcw_pkg::QCNT_W'(pcw_pkg::QDEPTH))
		else $error("queue fill count above depth");

endmodule

[sv/pcw_back.sv]
`timescale 1ns / 1ps
// Back end: corner cross products, turn sign tracking and winding accumulation.
module pcw_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pcw_pkg::EPS_W-1:0]   cross_epsilon,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  pcw_pkg::pcw_vtx_t           pop_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        is_convex,
	output logic                        too_few_points,
	output logic                        winding_negative
);

	localparam int DIF_W  = pcw_pkg::COORD_W + 1;
	localparam int PROD_W = 2 * DIF_W;
	localparam int CR_W   = PROD_W + 1;

	// ops run for one queued vertex; the closing vertex runs all three
	typedef enum logic [1:0] {
		OP_VERTEX = 2'd0,
		OP_CLOSE  = 2'd1,
		OP_WRAP   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		SIGN_NONE = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2
	} sign_t;

	typedef struct packed {
		logic corner_en;
		logic edge_en;
		logic done;
		logic too_few;
	} ctl_t;

	op_t                       op_q;
	sign_t                     sign_q;
	logic                      conflict_q;
	logic [pcw_pkg::ACC_W-1:0] acc_q;
	logic                      res_valid_q;
	logic                      convex_q;
	logic                      few_q;
	logic                      wneg_q;

	pcw_pkg::pcw_pt_t first_q, second_q, older_q, newer_q;
	pcw_pkg::pcw_pt_t pa, pb, pc;

	logic                     v_s1, v_s2, v_s3;
	ctl_t                     ctl_i, ctl_s1, ctl_s2, ctl_s3;
	logic signed [DIF_W-1:0]  d1x_s1, d1y_s1, d2x_s1, d2y_s1, eb_s1;
	logic signed [PROD_W-1:0] m1_s2, m2_s2, me_s2;
	logic signed [CR_W-1:0]   cr_s3;
	logic signed [PROD_W-1:0] term_s3;

	logic                      adv;
	logic                      issue;
	logic                      fire;
	logic signed [CR_W-1:0]    eps_w;
	logic                      gt, lt;
	sign_t                     turn;
	sign_t                     sign_nx;
	logic                      conflict_nx;
	logic [pcw_pkg::ACC_W-1:0] acc_nx;

	// the whole back end advances when the result register can take a beat
	assign adv       = !res_valid_q || res_ready;
	assign issue     = adv && pop_valid;
	assign pop_ready = adv && (!pop_data.last || op_q == OP_WRAP);
	assign fire      = adv && v_s3;

	always_comb begin
		ctl_i         = '0;
		ctl_i.too_few = pop_data.too_few;
		unique case (op_q)
			OP_VERTEX: begin
				pa              = older_q;
				pb              = newer_q;
				pc              = pop_data.pt;
				ctl_i.corner_en = pop_data.cls == pcw_pkg::CLS_MORE;
				ctl_i.edge_en   = pop_data.cls != pcw_pkg::CLS_FIRST;
				ctl_i.done      = 1'b0;
			end
			OP_CLOSE: begin
				// closing edge back to the first vertex
				pa              = older_q;
				pb              = newer_q;
				pc              = first_q;
				ctl_i.corner_en = pop_data.cls == pcw_pkg::CLS_MORE;
				ctl_i.edge_en   = 1'b1;
				ctl_i.done      = 1'b0;
			end
			OP_WRAP: begin
				pa              = newer_q;
				pb              = first_q;
				pc              = second_q;
				ctl_i.corner_en = pop_data.cls == pcw_pkg::CLS_MORE;
				ctl_i.edge_en   = 1'b0;
				ctl_i.done      = 1'b1;
			end
			default: begin
				pa              = older_q;
				pb              = newer_q;
				pc              = pop_data.pt;
				ctl_i.corner_en = 1'b0;
				ctl_i.edge_en   = 1'b0;
				ctl_i.done      = 1'b0;
			end
		endcase
	end

	// final stage: classify the turn and fold it into the polygon state
	always_comb begin
		eps_w = $signed({{(CR_W - pcw_pkg::EPS_W){1'b0}}, cross_epsilon});
		gt    = cr_s3 > eps_w;
		lt    = (cr_s3 + eps_w) < $signed(CR_W'(0));
		turn  = gt ? SIGN_POS : SIGN_NEG;
		sign_nx     = sign_q;
		conflict_nx = conflict_q;
		if (ctl_s3.corner_en && (gt || lt)) begin
			if (sign_q == SIGN_NONE) begin
				sign_nx = turn;
			end else if (sign_q != turn) begin
				conflict_nx = 1'b1;
			end
		end
		acc_nx = ctl_s3.edge_en ? acc_q + pcw_pkg::ACC_W'(term_s3) : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_VERTEX;
			sign_q      <= SIGN_NONE;
			conflict_q  <= 1'b0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
		end else begin
			if (issue && pop_data.last) begin
				unique case (op_q)
					OP_VERTEX: op_q <= OP_CLOSE;
					OP_CLOSE:  op_q <= OP_WRAP;
					default:   op_q <= OP_VERTEX;
				endcase
			end
			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (fire) begin
				if (ctl_s3.done) begin
					sign_q     <= SIGN_NONE;
					conflict_q <= 1'b0;
					acc_q      <= '0;
				end else begin
					sign_q     <= sign_nx;
					conflict_q <= conflict_nx;
					acc_q      <= acc_nx;
				end
			end
			if (fire && ctl_s3.done) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue && op_q == OP_VERTEX) begin
			if (pop_data.cls == pcw_pkg::CLS_FIRST) begin
				first_q <= pop_data.pt;
			end
			if (pop_data.cls == pcw_pkg::CLS_SECOND) begin
				second_q <= pop_data.pt;
			end
			older_q <= newer_q;
			newer_q <= pop_data.pt;
		end
		if (adv) begin
			ctl_s1 <= ctl_i;
			d1x_s1 <= DIF_W'(pb.a) - DIF_W'(pa.a);
			d1y_s1 <= DIF_W'(pb.b) - DIF_W'(pa.b);
			d2x_s1 <= DIF_W'(pc.a) - DIF_W'(pb.a);
			d2y_s1 <= DIF_W'(pc.b) - DIF_W'(pb.b);
			eb_s1  <= DIF_W'(pc.b) + DIF_W'(pb.b);
			ctl_s2 <= ctl_s1;
			m1_s2  <= d1x_s1 * d2y_s1;
			m2_s2  <= d1y_s1 * d2x_s1;
			me_s2  <= d2x_s1 * eb_s1;
			ctl_s3  <= ctl_s2;
			cr_s3   <= CR_W'(m1_s2) - CR_W'(m2_s2);
			term_s3 <= me_s2;
		end
		if (fire && ctl_s3.done) begin
			convex_q <= !ctl_s3.too_few && !conflict_nx;
			few_q    <= ctl_s3.too_few;
			wneg_q   <= (acc_nx != '0) && !acc_nx[pcw_pkg::ACC_W-1];
		end
	end

	assign res_valid        = res_valid_q;
	assign is_convex        = convex_q;
	assign too_few_points   = few_q;
	assign winding_negative = wneg_q;

	a_conflict_sign: assert property (@(posedge clk) disable iff (!arst_n)
		conflict_q |-> sign_q != SIGN_NONE)
		else $error("sign conflict without a recorded turn sign");

	a_close_ops: assert property (@(posedge clk) disable iff (!arst_n)
		op_q != OP_VERTEX |-> pop_valid && pop_data.last)
		else $error("closing ops without a closing vertex at queue head");

	a_result_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(v_s3) && $past(ctl_s3.done))
		else $error("result raised without a finished polygon");

endmodule

[sv/polygon_convexity_and_winding.sv]
`timescale 1ns / 1ps
// Polygon convexity and winding checker: one vertex beat per clock cycle enters a
// four-entry queue while it has room. The closing vertex (tlast) stays at the
// queue head while it runs the vertex, close and wrap ops through the shared
// cross-product and winding multiplier stage, because it also covers the closing
// edge and the two wrap-around corners. The wrap op passes s1, s2 and s3 into the
// result register, whose beat holds the back end while waiting on m_tready and
// the front end fills the queue. There is no clearing pass after reset.
module polygon_convexity_and_winding #(
	parameter int MAX_VERTICES = 1023
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [71:0]                       s_tdata,   // coord_x, coord_y, coord_z
	input  logic                              s_tlast,   // last_vertex
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // is_convex, too_few_points,
	                                                     // winding_negative, zero fill
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcw_pkg::CFG_DAT_W-1:0]     cfg_data
);

	localparam int CW = pcw_pkg::COORD_W;

	pcw_pkg::pcw_cfg_t cfg_q;
	pcw_pkg::pcw_vtx_t push_data, pop_data;
	logic              push_valid, push_ready, pop_valid, pop_ready;
	logic              is_convex, too_few_points, winding_negative;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.view_plane    <= pcw_pkg::VIEW_RESET;
			cfg_q.cross_epsilon <= pcw_pkg::EPS_RESET;
			cfg_q.min_points    <= pcw_pkg::MINP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pcw_pkg::CFG_VIEW_PLANE:
					cfg_q.view_plane <= cfg_data[pcw_pkg::VIEW_W-1:0];
				pcw_pkg::CFG_CROSS_EPSILON:
					cfg_q.cross_epsilon <= cfg_data[pcw_pkg::EPS_W-1:0];
				pcw_pkg::CFG_MIN_POINTS:
					cfg_q.min_points <= cfg_data[pcw_pkg::MINP_W-1:0];
				default: ;
			endcase
		end
	end

	pcw_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.coord_x    ($signed(s_tdata[CW-1:0])),
		.coord_y    ($signed(s_tdata[2*CW-1:CW])),
		.coord_z    ($signed(s_tdata[3*CW-1:2*CW])),
		.last_vertex(s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	pcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	pcw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cross_epsilon   (cfg_q.cross_epsilon),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_data        (pop_data),
		.res_valid       (m_tvalid),
		.res_ready       (m_tready),
		.is_convex       (is_convex),
		.too_few_points  (too_few_points),
		.winding_negative(winding_negative)
	);

	assign m_tdata = {5'b0, winding_negative, too_few_points, is_convex};

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench: vertex stream in, polygon verdicts checked against a local predictor.
module tb_top;

	// Counter limit kept small so a run can pass it; it stays above any min_points value
	localparam int          MAX_VERTICES = 130;
	localparam int          SETTLE       = 16;
	localparam int          QUIET_LIMIT  = 2000;
	localparam real         TWO_PI       = 6.283185307179586;
	localparam logic [pcw_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		TURN_NONE = 2'd0,
		TURN_POS  = 2'd1,
		TURN_NEG  = 2'd2
	} turn_t;

	typedef struct packed {
		logic winding_negative;
		logic too_few_points;
		logic is_convex;
	} verdict_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [71:0]                   s_tdata   = '0;   // coord_x, coord_y, coord_z
	logic                          s_tlast   = 1'b0; // last_vertex
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [7:0]                    m_tdata;          // is_convex, too_few_points, winding_negative
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [pcw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pcw_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

	polygon_convexity_and_winding #(
		.MAX_VERTICES(MAX_VERTICES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Register shadows
	logic [pcw_pkg::VIEW_W-1:0] plane_sel = pcw_pkg::VIEW_RESET;
	logic [pcw_pkg::EPS_W-1:0]  eps_q     = pcw_pkg::EPS_RESET;
	logic [pcw_pkg::MINP_W-1:0] minp_q    = pcw_pkg::MINP_RESET;

	// Polygon state of the predictor
	pcw_pkg::pcw_pt_t          first_pt;
	pcw_pkg::pcw_pt_t          second_pt;
	pcw_pkg::pcw_pt_t          older_pt;
	pcw_pkg::pcw_pt_t          newer_pt;
	turn_t                     turn_dir;
	logic                      sign_clash;
	logic [pcw_pkg::ACC_W-1:0] wind_sum;
	logic [9:0]                vtx_count;

	verdict_t    pending_verdicts[$];
	int unsigned mismatches   = 0;
	int unsigned sent_items   = 0;
	int unsigned quiet_cycles = 0;
	bit          steady       = 1'b0;

	function automatic void clear_polygon();
		first_pt   = '0;
		second_pt  = '0;
		older_pt   = '0;
		newer_pt   = '0;
		turn_dir   = TURN_NONE;
		sign_clash = 1'b0;
		wind_sum   = '0;
		vtx_count  = '0;
	endfunction

	function automatic void note_turn(pcw_pkg::pcw_pt_t p0, pcw_pkg::pcw_pt_t p1,
	                                  pcw_pkg::pcw_pt_t p2);
		longint e1a, e1b, e2a, e2b, wedge, limit;
		turn_t  dir;
		e1a   = longint'($signed(p1.a)) - longint'($signed(p0.a));
		e1b   = longint'($signed(p1.b)) - longint'($signed(p0.b));
		e2a   = longint'($signed(p2.a)) - longint'($signed(p1.a));
		e2b   = longint'($signed(p2.b)) - longint'($signed(p1.b));
		wedge = e1a * e2b - e1b * e2a;
		limit = longint'(eps_q);
		if (wedge > limit) begin
			dir = TURN_POS;
		end else if (wedge < -limit) begin
			dir = TURN_NEG;
		end else begin
			return;
		end
		if (turn_dir == TURN_NONE) begin
			turn_dir = dir;
		end else if (turn_dir != dir) begin
			sign_clash = 1'b1;
		end
	endfunction

	function automatic void add_edge(pcw_pkg::pcw_pt_t from_pt, pcw_pkg::pcw_pt_t to_pt);
		longint term;
		term = (longint'($signed(to_pt.a)) - longint'($signed(from_pt.a))) *
		       (longint'($signed(to_pt.b)) + longint'($signed(from_pt.b)));
		wind_sum = wind_sum + term[pcw_pkg::ACC_W-1:0];
	endfunction

	// Advance the predictor by one accepted vertex beat
	function automatic void trace_vertex(logic signed [pcw_pkg::COORD_W-1:0] x,
	                                     logic signed [pcw_pkg::COORD_W-1:0] y,
	                                     logic signed [pcw_pkg::COORD_W-1:0] z, logic closing);
		pcw_pkg::pcw_pt_t cur;
		logic [9:0]       seen;
		verdict_t         v;
		seen = vtx_count;
		case (plane_sel)
			pcw_pkg::VIEW_YZ: begin
				cur.a = y;
				cur.b = z;
			end
			pcw_pkg::VIEW_XZ: begin
				cur.a = x;
				cur.b = z;
			end
			default: begin
				cur.a = x;
				cur.b = y;
			end
		endcase
		if (seen == 0) begin
			first_pt = cur;
		end else begin
			add_edge(newer_pt, cur);
			if (seen == 1) begin
				second_pt = cur;
			end else begin
				note_turn(older_pt, newer_pt, cur);
			end
		end
		older_pt = newer_pt;
		newer_pt = cur;
		if (vtx_count < MAX_VERTICES) begin
			vtx_count = vtx_count + 10'd1;
		end
		if (closing) begin
			add_edge(cur, first_pt);
			if (seen >= 2) begin
				note_turn(older_pt, cur, first_pt);
				note_turn(cur, first_pt, second_pt);
			end
			v.too_few_points   = vtx_count < {3'b0, minp_q};
			v.is_convex        = !v.too_few_points && !sign_clash;
			v.winding_negative = (wind_sum != '0) && !wind_sum[pcw_pkg::ACC_W-1];
			pending_verdicts.insert(pending_verdicts.size(), v);
			clear_polygon();
		end
	endfunction

	function automatic void note_register(logic [pcw_pkg::CFG_IDX_W-1:0] idx,
	                                      logic [pcw_pkg::CFG_DAT_W-1:0] d);
		case (idx)
			pcw_pkg::CFG_VIEW_PLANE:    plane_sel = d[pcw_pkg::VIEW_W-1:0];
			pcw_pkg::CFG_CROSS_EPSILON: eps_q     = d[pcw_pkg::EPS_W-1:0];
			pcw_pkg::CFG_MIN_POINTS:    minp_q    = d[pcw_pkg::MINP_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void check_field(string what, logic want, logic got);
		if (want !== got) begin
			$display("%0t: %s expected %0b actual %0b", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Result checker
	always @(posedge clk) begin
		verdict_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = verdict_t'(m_tdata[2:0]);
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result beat expected none actual %b", $time, m_tdata);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("is_convex", want.is_convex, got.is_convex);
				check_field("too_few_points", want.too_few_points, got.too_few_points);
				check_field("winding_negative", want.winding_negative, got.winding_negative);
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 28);
	end

	// Watchdog: end the run once nothing has moved for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_vertex(input logic signed [pcw_pkg::COORD_W-1:0] x,
	                           input logic signed [pcw_pkg::COORD_W-1:0] y,
	                           input logic signed [pcw_pkg::COORD_W-1:0] z, input logic closing);
		if (!steady) begin
			while ($urandom_range(0, 99) < 28) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x};
		s_tlast  <= closing;
		do @(posedge clk); while (!s_tready);
		trace_vertex(x, y, z, closing);
		sent_items++;
	endtask

	// Pause input until every verdict is back, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [pcw_pkg::VIEW_W-1:0] view,
	                              input logic [pcw_pkg::EPS_W-1:0] eps,
	                              input logic [pcw_pkg::MINP_W-1:0] minp, input bit poke_unused);
		logic [pcw_pkg::CFG_IDX_W-1:0] regs [4];
		logic [pcw_pkg::CFG_DAT_W-1:0] vals [4];
		int                            n;
		regs[0] = pcw_pkg::CFG_VIEW_PLANE;
		regs[1] = pcw_pkg::CFG_CROSS_EPSILON;
		regs[2] = pcw_pkg::CFG_MIN_POINTS;
		regs[3] = CFG_UNUSED;
		vals[0] = pcw_pkg::CFG_DAT_W'($urandom);
		vals[0][pcw_pkg::VIEW_W-1:0] = view;
		vals[1] = eps;
		vals[2] = pcw_pkg::CFG_DAT_W'($urandom);
		vals[2][pcw_pkg::MINP_W-1:0] = minp;
		vals[3] = pcw_pkg::CFG_DAT_W'($urandom);
		n = poke_unused ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			note_register(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Map a drawing-plane point onto x, y, z with a random off-plane coordinate
	task automatic send_plane_pt(input int a, input int b, input logic closing);
		logic signed [pcw_pkg::COORD_W-1:0] ca, cb, other;
		ca    = a[pcw_pkg::COORD_W-1:0];
		cb    = b[pcw_pkg::COORD_W-1:0];
		other = pcw_pkg::COORD_W'($urandom);
		case (plane_sel)
			pcw_pkg::VIEW_YZ: send_vertex(other, ca, cb, closing);
			pcw_pkg::VIEW_XZ: send_vertex(ca, other, cb, closing);
			default:          send_vertex(ca, cb, other, closing);
		endcase
	endtask

	// Regular polygon on a circle; a dent pulls one vertex across the center
	task automatic send_ring(input int n, input int radius, input bit cw, input bit dent);
		real ang, r;
		int  lim, cx, cy, a, b;
		lim = 8388600 - radius;
		cx  = int'($urandom_range(0, 2 * lim)) - lim;
		cy  = int'($urandom_range(0, 2 * lim)) - lim;
		for (int k = 0; k < n; k++) begin
			ang = TWO_PI * k / n;
			r   = (dent && k == n / 2) ? -0.3 * radius : radius;
			a   = cx + $rtoi(r * $cos(ang));
			b   = cy + (cw ? -$rtoi(r * $sin(ang)) : $rtoi(r * $sin(ang)));
			send_plane_pt(a, b, k == n - 1);
		end
	endtask

	task automatic send_scatter(input int n, input int span);
		for (int k = 0; k < n; k++) begin
			send_plane_pt(int'($urandom_range(0, 2 * span)) - span,
			              int'($urandom_range(0, 2 * span)) - span, k == n - 1);
		end
	endtask

	task automatic send_noise(input int n);
		logic signed [pcw_pkg::COORD_W-1:0] x, y, z;
		for (int k = 0; k < n; k++) begin
			x = pcw_pkg::COORD_W'($urandom);
			y = pcw_pkg::COORD_W'($urandom);
			z = pcw_pkg::COORD_W'($urandom);
			send_vertex(x, y, z, k == n - 1);
		end
	endtask

	function automatic int pick_radius();
		case ($urandom_range(0, 2))
			0:       return int'($urandom_range(1, 40));
			1:       return int'($urandom_range(41, 5000));
			default: return int'($urandom_range(5001, 4000000));
		endcase
	endfunction

	// Mostly well-formed polygons, the rest scattered points and raw noise
	task automatic pick_polygon();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			send_ring($urandom_range(3, 12), pick_radius(), 1'($urandom_range(0, 1)), 1'b0);
		end else if (roll < 75) begin
			send_ring($urandom_range(4, 12), pick_radius(), 1'($urandom_range(0, 1)), 1'b1);
		end else if (roll < 90) begin
			send_scatter($urandom_range(3, 8), $urandom_range(0, 1) ? 60 : 8388607);
		end else begin
			send_noise($urandom_range(1, 5));
		end
	endtask

	task automatic run_polygons(input int unsigned count);
		int unsigned start;
		start = sent_items;
		while (sent_items - start < count) pick_polygon();
	endtask

	task automatic check_directed_shapes();
		localparam logic signed [pcw_pkg::COORD_W-1:0] HI = 24'sh7FFFFF;
		localparam logic signed [pcw_pkg::COORD_W-1:0] LO = -24'sh800000;
		// lone vertex, then a two-vertex run
		send_vertex(HI, HI, HI, 1'b1);
		send_vertex(LO, LO, LO, 1'b0);
		send_vertex(HI, HI, 24'sd0, 1'b1);
		// counterclockwise and clockwise triangles
		send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
		send_vertex(24'sd1000, 24'sd0, 24'sd0, 1'b0);
		send_vertex(24'sd0, 24'sd1000, 24'sd0, 1'b1);
		send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
		send_vertex(24'sd0, 24'sd1000, 24'sd0, 1'b0);
		send_vertex(24'sd1000, 24'sd0, 24'sd0, 1'b1);
		// arrowhead with one reflex corner
		send_vertex(24'sd0, 24'sd0, 24'sd5, 1'b0);
		send_vertex(24'sd1000, 24'sd0, 24'sd5, 1'b0);
		send_vertex(24'sd200, 24'sd200, 24'sd5, 1'b0);
		send_vertex(24'sd0, 24'sd1000, 24'sd5, 1'b1);
		// collinear points
		send_vertex(24'sd0, 24'sd0, LO, 1'b0);
		send_vertex(24'sd100, 24'sd0, LO, 1'b0);
		send_vertex(24'sd200, 24'sd0, LO, 1'b1);
		// square on the coordinate extremes
		send_vertex(HI, HI, LO, 1'b0);
		send_vertex(LO, HI, HI, 1'b0);
		send_vertex(LO, LO, LO, 1'b0);
		send_vertex(HI, LO, HI, 1'b1);
		// corners exactly at the threshold, then just above it
		send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
		send_vertex(24'sd66, 24'sd0, 24'sd0, 1'b0);
		send_vertex(24'sd66, 24'sd1, 24'sd0, 1'b1);
		send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
		send_vertex(24'sd67, 24'sd0, 24'sd0, 1'b0);
		send_vertex(24'sd67, 24'sd1, 24'sd0, 1'b1);
		drain();
	endtask

	task automatic check_view_planes();
		for (int v = 0; v < 4; v++) begin
			apply_settings(v[pcw_pkg::VIEW_W-1:0], pcw_pkg::EPS_RESET, pcw_pkg::MINP_RESET, 1'b0);
			run_polygons(15);
			drain();
		end
	endtask

	task automatic check_turn_threshold();
		logic [pcw_pkg::EPS_W-1:0] levels [4];
		levels[0] = '0;
		levels[1] = 20'd1;
		levels[2] = '1;
		levels[3] = pcw_pkg::EPS_W'($urandom_range(2, 5000));
		foreach (levels[i]) begin
			apply_settings(pcw_pkg::VIEW_W'($urandom_range(0, 3)), levels[i],
			               pcw_pkg::MINP_RESET, 1'b0);
			run_polygons(15);
			drain();
		end
	endtask

	task automatic check_min_points();
		int marks [6];
		marks = '{0, 1, 2, 5, 64, 127};
		foreach (marks[i]) begin
			apply_settings(pcw_pkg::VIEW_W'($urandom_range(0, 3)), pcw_pkg::EPS_RESET,
			               pcw_pkg::MINP_W'(marks[i]), i == 2);
			if (marks[i] <= 64) begin
				for (int d = -1; d <= 1; d++) begin
					send_ring((marks[i] + d < 1) ? 1 : marks[i] + d, pick_radius(),
					          1'($urandom_range(0, 1)), 1'b0);
				end
			end else begin
				run_polygons(12);
			end
			send_noise($urandom_range(1, 3));
			drain();
		end
	endtask

	// Run past the vertex counter limit, with no idling on either side
	task automatic check_count_saturation();
		apply_settings(pcw_pkg::VIEW_XY, pcw_pkg::EPS_RESET, pcw_pkg::MINP_RESET, 1'b0);
		steady = 1'b1;
		send_ring(MAX_VERTICES + 7, 4000000, 1'b0, 1'b0);
		drain();
		steady = 1'b0;
	endtask

	task automatic check_random_polygons();
		logic [pcw_pkg::EPS_W-1:0]  eps;
		logic [pcw_pkg::MINP_W-1:0] minp;
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 3))
				0:       eps = '0;
				1:       eps = pcw_pkg::EPS_W'($urandom_range(1, 200));
				2:       eps = pcw_pkg::EPS_W'($urandom);
				default: eps = '1;
			endcase
			minp = pcw_pkg::MINP_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2)
			                                                     : $urandom_range(3, 8));
			apply_settings(pcw_pkg::VIEW_W'($urandom_range(0, 3)), eps, minp, 1'b0);
			run_polygons(15);
			drain();
		end
	endtask

	initial begin
		clear_polygon();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_directed_shapes();
		check_view_planes();
		check_turn_threshold();
		check_min_points();
		check_count_saturation();
		check_random_polygons();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/pcw_pkg.sv
sv/pcw_front.sv
sv/pcw_queue.sv
sv/pcw_back.sv
sv/polygon_convexity_and_winding.sv
tb/sv/tb_top.sv
